[sv/fsc_pkg.sv]
// Shared definitions for the frustum sphere cull block.
// Holds default widths and the request operation codes; no dependencies.
`default_nettype none
package fsc_pkg;
   localparam int WORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int NUM_PLANES    = 6;

   localparam logic [1:0] OP_LOAD_MV  = 2'd0;
   localparam logic [1:0] OP_LOAD_PJ  = 2'd1;
   localparam logic [1:0] OP_UPDATE   = 2'd2;
   localparam logic [1:0] OP_TEST     = 2'd3;
endpackage
`default_nettype wire

[sv/fsc_fmul.sv]
// Shared fixed point multiplier: exact magnitude product plus the
// shifted, truncated toward zero and saturated signed result. No dependencies.
`default_nettype none
module fsc_fmul #(
   parameter int W = 32,
   parameter int F = 16
) (
   input  wire logic signed [W-1:0] op_a,
   input  wire logic signed [W-1:0] op_b,
   output logic [2*W-1:0]           prod_raw,
   output logic signed [W-1:0]      prod_fix
);
   localparam int SW = 2 * W - F;
   localparam logic [SW-1:0] LIM_POS = SW'({(W-1){1'b1}});
   localparam logic [SW-1:0] LIM_NEG = LIM_POS + SW'(1);

   logic [W-1:0]  mag_a;
   logic [W-1:0]  mag_b;
   logic [SW-1:0] shifted;
   logic          neg;

   always_comb begin
      mag_a    = op_a[W-1] ? (~op_a + W'(1)) : op_a;
      mag_b    = op_b[W-1] ? (~op_b + W'(1)) : op_b;
      prod_raw = mag_a * mag_b;
      shifted  = prod_raw[2*W-1:F];
      neg      = op_a[W-1] ^ op_b[W-1];
      if (neg) begin
         if (shifted > LIM_NEG) prod_fix = {1'b1, {(W-1){1'b0}}};
         else prod_fix = ~shifted[W-1:0] + W'(1);
      end else begin
         if (shifted > LIM_POS) prod_fix = {1'b0, {(W-1){1'b1}}};
         else prod_fix = shifted[W-1:0];
      end
   end
endmodule
`default_nettype wire

[sv/frustum_sphere_cull.sv]
// Top level of the frustum sphere cull block: matrix stores, plane
// extraction and sphere test sequencer. Uses fsc_pkg and fsc_fmul.
//
// A load writes its matrix entry directly when accepted. A sphere test runs
// up to six planes of four steps each through the one shared multiplier,
// stops at the first plane that rejects the sphere, then posts the result.
// An update forms the clip matrix on the multiplier, then does for each
// plane four sums, three squares, a bit-serial root and four bit-serial divides.
// The block takes no request while a test or update is in progress.
`default_nettype none
module frustum_sphere_cull #(
   parameter int WORD_BITS = fsc_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = fsc_pkg::FRAC_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_op,
   input  wire logic [3:0]         req_entry_index,
   input  wire logic signed [31:0] req_entry_value,
   input  wire logic signed [31:0] req_center_x,
   input  wire logic signed [31:0] req_center_y,
   input  wire logic signed [31:0] req_center_z,
   input  wire logic [30:0]        req_radius,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_inside_res
);
   localparam int W  = WORD_BITS;
   localparam int F  = FRAC_BITS;
   localparam int QW = W + F;
   localparam int IW = (W > 32) ? W : 32;
   localparam int CW = ((W > 31) ? W : 31) + 2;
   localparam int ITB = $clog2(QW);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CLIP   = 3'd1;
   localparam logic [2:0] S_PSUM   = 3'd2;
   localparam logic [2:0] S_SQ     = 3'd3;
   localparam logic [2:0] S_SQRT   = 3'd4;
   localparam logic [2:0] S_DIV    = 3'd5;
   localparam logic [2:0] S_TEST   = 3'd6;
   localparam logic [2:0] S_RESULT = 3'd7;

   localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [IW-1:0] IMAX = IW'({1'b0, {(W-1){1'b1}}});
   localparam logic signed [IW-1:0] IMIN = -IMAX - IW'(1);
   localparam logic [QW-1:0] QLIM_POS = QW'({(W-1){1'b1}});
   localparam logic [QW-1:0] QLIM_NEG = QLIM_POS + QW'(1);
   localparam logic [2:0] LAST_PLANE = 3'(fsc_pkg::NUM_PLANES - 1);

   function automatic logic signed [W-1:0] in_word(input logic signed [31:0] x);
      logic signed [IW-1:0] v;
      v = IW'(x);
      if (v > IMAX) return WMAX;
      if (v < IMIN) return WMIN;
      return v[W-1:0];
   endfunction

   function automatic logic signed [W-1:0] sat_sum(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b,
                                                  input logic sub);
      logic signed [W:0] s;
      s = sub ? ((W+1)'(a) - (W+1)'(b)) : ((W+1)'(a) + (W+1)'(b));
      if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
      return s[W-1:0];
   endfunction

   function automatic logic [W-1:0] mag(input logic signed [W-1:0] a);
      return a[W-1] ? (~a + W'(1)) : a;
   endfunction

   logic signed [W-1:0] mv_ff  [16];
   logic signed [W-1:0] pj_ff  [16];
   logic signed [W-1:0] clip_ff[16];
   logic signed [W-1:0] pl_ff  [24];
   logic signed [W-1:0] p_ff   [4];
   logic signed [W-1:0] cen_ff [3];
   logic [30:0]         rad_ff;

   logic [2:0]          state_ff, state_in;
   logic [2:0]          k_ff, k_in;
   logic [2:0]          j_ff, j_in;
   logic [ITB-1:0]      it_ff, it_in;
   logic signed [W-1:0] acc_ff, acc_in;
   logic [2*W-1:0]      sum_ff, sum_in;
   logic [2*W-1:0]      work_ff, work_in;
   logic [W+1:0]        rem_ff, rem_in;
   logic [QW-1:0]       qr_ff, qr_in;
   logic [QW-1:0]       num_ff, num_in;
   logic [W-1:0]        len_ff, len_in;
   logic                res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_inside_ff, rsp_inside_in;

   logic signed [W-1:0] mul_a, mul_b, prod_fix;
   logic [2*W-1:0]      prod_raw;
   logic                req_accept;
   logic                clip_we, p_we, pl_we;
   logic [3:0]          clip_addr, mv_addr;
   logic signed [W-1:0] clip_wdata, p_wdata, pl_wdata;
   logic [4:0]          pl_addr;
   logic [1:0]          row;
   logic                plus;
   logic [W+1:0]        rem_sh, trial;
   logic [QW-1:0]       q_next;
   logic                neg_p;
   logic signed [W-1:0] dot;
   logic signed [CW-1:0] cmp_sum;

   fsc_fmul #(.W(W), .F(F)) u_fmul (
      .op_a     (mul_a),
      .op_b     (mul_b),
      .prod_raw (prod_raw),
      .prod_fix (prod_fix)
   );

   assign req_stall      = (state_ff != S_IDLE);
   assign req_accept     = req_valid && !req_stall;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;

   always_comb begin
      row     = k_ff[2:1];
      plus    = (k_ff == 3'd1) || (k_ff == 3'd2) || (k_ff == 3'd5);
      pl_addr = {k_ff[2:0], j_ff[1:0]} - 5'd0;
      pl_addr = {k_ff[2:0], 2'b00} + {3'b000, j_ff[1:0]};
      mv_addr = {k_ff[1:0], j_ff[1:0]};
      mul_a   = '0;
      mul_b   = '0;
      case (state_ff)
         S_CLIP: begin
            case (j_ff)
               3'd0: begin
                  mv_addr = {k_ff[1:0], 2'd0};
                  mul_b   = pj_ff[0];
               end
               3'd1: begin
                  mv_addr = {k_ff[1:0], 2'd1};
                  mul_b   = pj_ff[5];
               end
               3'd2: begin
                  mv_addr = {k_ff[1:0], 2'd2};
                  mul_b   = pj_ff[10];
               end
               3'd3: begin
                  mv_addr = {k_ff[1:0], 2'd3};
                  mul_b   = pj_ff[14];
               end
               default: begin
                  mv_addr = {k_ff[1:0], 2'd2};
                  mul_b   = pj_ff[11];
               end
            endcase
            mul_a = mv_ff[mv_addr];
         end
         S_SQ: begin
            mul_a = p_ff[j_ff[1:0]];
            mul_b = p_ff[j_ff[1:0]];
         end
         S_TEST: begin
            mul_a = pl_ff[pl_addr];
            mul_b = cen_ff[(j_ff[1:0] == 2'd3) ? 2'd0 : j_ff[1:0]];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      j_in          = j_ff;
      it_in         = it_ff;
      acc_in        = acc_ff;
      sum_in        = sum_ff;
      work_in       = work_ff;
      rem_in        = rem_ff;
      qr_in         = qr_ff;
      num_in        = num_ff;
      len_in        = len_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_inside_in = rsp_inside_ff;
      clip_we       = 1'b0;
      clip_addr     = {k_ff[1:0], j_ff[1:0]};
      clip_wdata    = prod_fix;
      p_we          = 1'b0;
      p_wdata       = sat_sum(clip_ff[{j_ff[1:0], 2'd3}], clip_ff[{j_ff[1:0], row}], !plus);
      pl_we         = 1'b0;
      pl_wdata      = '0;
      rem_sh        = '0;
      trial         = '0;
      q_next        = qr_ff;
      neg_p         = p_ff[j_ff[1:0]][W-1];
      dot           = sat_sum(acc_ff, pl_ff[pl_addr], 1'b0);
      cmp_sum       = CW'(dot) + CW'({1'b0, rad_ff});

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               k_in = '0;
               j_in = '0;
               if (req_op == fsc_pkg::OP_UPDATE) state_in = S_CLIP;
               else if (req_op == fsc_pkg::OP_TEST) state_in = S_TEST;
            end
         end
         S_CLIP: begin
            case (j_ff)
               3'd0: begin
                  clip_we   = 1'b1;
                  clip_addr = {k_ff[1:0], 2'd0};
               end
               3'd1: begin
                  clip_we   = 1'b1;
                  clip_addr = {k_ff[1:0], 2'd1};
               end
               3'd2: acc_in = prod_fix;
               3'd3: begin
                  clip_we    = 1'b1;
                  clip_addr  = {k_ff[1:0], 2'd2};
                  clip_wdata = sat_sum(acc_ff, prod_fix, 1'b0);
               end
               default: begin
                  clip_we   = 1'b1;
                  clip_addr = {k_ff[1:0], 2'd3};
               end
            endcase
            if (j_ff == 3'd4) begin
               j_in = '0;
               if (k_ff == 3'd3) begin
                  k_in     = '0;
                  state_in = S_PSUM;
               end else k_in = k_ff + 3'd1;
            end else j_in = j_ff + 3'd1;
         end
         S_PSUM: begin
            p_we = 1'b1;
            if (j_ff == 3'd3) begin
               j_in     = '0;
               sum_in   = '0;
               state_in = S_SQ;
            end else j_in = j_ff + 3'd1;
         end
         S_SQ: begin
            sum_in = sum_ff + prod_raw;
            if (j_ff == 3'd2) begin
               work_in  = sum_ff + prod_raw;
               rem_in   = '0;
               qr_in    = '0;
               it_in    = ITB'(W - 1);
               j_in     = '0;
               state_in = S_SQRT;
            end else j_in = j_ff + 3'd1;
         end
         S_SQRT: begin
            rem_sh  = {rem_ff[W-1:0], work_ff[2*W-1:2*W-2]};
            trial   = {qr_ff[W-1:0], 2'b01};
            work_in = {work_ff[2*W-3:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in = rem_sh - trial;
               q_next = {qr_ff[QW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               q_next = {qr_ff[QW-2:0], 1'b0};
            end
            qr_in = q_next;
            it_in = it_ff - ITB'(1);
            if (it_ff == '0) begin
               len_in   = q_next[W-1:0];
               rem_in   = '0;
               qr_in    = '0;
               num_in   = {mag(p_ff[0]), {F{1'b0}}};
               it_in    = ITB'(QW - 1);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_sh = {rem_ff[W:0], num_ff[QW-1]};
            num_in = {num_ff[QW-2:0], 1'b0};
            if (rem_sh >= {2'b00, len_ff}) begin
               rem_in = rem_sh - {2'b00, len_ff};
               q_next = {qr_ff[QW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               q_next = {qr_ff[QW-2:0], 1'b0};
            end
            qr_in = q_next;
            it_in = it_ff - ITB'(1);
            if (it_ff == '0) begin
               pl_we = 1'b1;
               if (len_ff == '0) pl_wdata = '0;
               else if (neg_p) begin
                  if (q_next > QLIM_NEG) pl_wdata = WMIN;
                  else pl_wdata = ~q_next[W-1:0] + W'(1);
               end else begin
                  if (q_next > QLIM_POS) pl_wdata = WMAX;
                  else pl_wdata = q_next[W-1:0];
               end
               rem_in = '0;
               qr_in  = '0;
               it_in  = ITB'(QW - 1);
               if (j_ff == 3'd3) begin
                  j_in = '0;
                  if (k_ff == LAST_PLANE) state_in = S_IDLE;
                  else begin
                     k_in     = k_ff + 3'd1;
                     state_in = S_PSUM;
                  end
               end else begin
                  j_in   = j_ff + 3'd1;
                  num_in = {mag(p_ff[j_ff[1:0] + 2'd1]), {F{1'b0}}};
               end
            end
         end
         S_TEST: begin
            case (j_ff)
               3'd0: acc_in = prod_fix;
               3'd1, 3'd2: acc_in = sat_sum(acc_ff, prod_fix, 1'b0);
               default: acc_in = acc_ff;
            endcase
            if (j_ff == 3'd3) begin
               j_in = '0;
               if (cmp_sum <= CW'(0)) begin
                  res_in   = 1'b0;
                  state_in = S_RESULT;
               end else if (k_ff == LAST_PLANE) begin
                  res_in   = 1'b1;
                  state_in = S_RESULT;
               end else k_in = k_ff + 3'd1;
            end else j_in = j_ff + 3'd1;
         end
         S_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_inside_in = res_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         k_ff         <= '0;
         j_ff         <= '0;
         it_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         j_ff         <= j_in;
         it_ff        <= it_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff        <= acc_in;
      sum_ff        <= sum_in;
      work_ff       <= work_in;
      rem_ff        <= rem_in;
      qr_ff         <= qr_in;
      num_ff        <= num_in;
      len_ff        <= len_in;
      res_ff        <= res_in;
      rsp_inside_ff <= rsp_inside_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            mv_ff[i] <= '0;
            pj_ff[i] <= '0;
         end
         for (int i = 0; i < 24; i++) pl_ff[i] <= '0;
      end else begin
         if (req_accept && req_op == fsc_pkg::OP_LOAD_MV)
            mv_ff[req_entry_index] <= in_word(req_entry_value);
         if (req_accept && req_op == fsc_pkg::OP_LOAD_PJ)
            pj_ff[req_entry_index] <= in_word(req_entry_value);
         if (pl_we) pl_ff[pl_addr] <= pl_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (clip_we) clip_ff[clip_addr] <= clip_wdata;
      if (p_we) p_ff[j_ff[1:0]] <= p_wdata;
      if (req_accept && req_op == fsc_pkg::OP_TEST) begin
         cen_ff[0] <= in_word(req_center_x);
         cen_ff[1] <= in_word(req_center_y);
         cen_ff[2] <= in_word(req_center_z);
         rad_ff    <= req_radius;
      end
   end
endmodule
`default_nettype wire
